[rtl/core/pfi_pkg.sv]
// ----------------------------------------------------------------------------
// pfi_pkg
// Shared types and constants for the two-objective frontier insert block.
// ----------------------------------------------------------------------------
`default_nettype none

package pfi_pkg;

    localparam int FRONTIER_DEPTH = 16;
    localparam int FILL_W         = $clog2(FRONTIER_DEPTH + 1);

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_CLEAR  = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;

    localparam logic [1:0] ST_INSERTED  = 2'd0;
    localparam logic [1:0] ST_DOMINATED = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_DONE      = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] set;
        logic [5:0]  penalty;
        logic [30:0] cost;
    } t_entry;

    // per-cycle commands broadcast to every cell
    typedef struct packed {
        logic capture;  // latch the removal flags from the compare
        logic shift;    // close the lowest hole by one position
        logic load;     // write the new entry into the selected cell
    } t_cell_ctl;

    function automatic logic [4:0] sat5(input logic [FILL_W-1:0] v);
        if (v > FILL_W'(31) && FILL_W > 5) begin
            sat5 = 5'd31;
        end else begin
            sat5 = 5'(v);
        end
    endfunction

endpackage

`default_nettype wire

[rtl/core/pfi_cell.sv]
// ----------------------------------------------------------------------------
// pfi_cell
// One frontier slot: compares its entry with the broadcast candidate, holds
// its removal flag and takes its upper neighbour's contents during compaction.
// ----------------------------------------------------------------------------
`default_nettype none

module pfi_cell
    import pfi_pkg::*;
(
    input  wire       i_clk,
    input  wire       i_rst_n,
    input  t_cell_ctl i_ctl,
    input  t_entry    i_cand,
    input  wire       i_in_range,
    input  wire       i_load_sel,
    input  t_entry    i_nb_entry,
    input  wire       i_nb_gone,
    input  wire       i_prefix,
    output t_entry    o_entry,
    output logic      o_gone,
    output logic      o_prefix,
    output logic      o_beaten,
    output logic      o_gone_now
);

    t_entry r_entry;
    logic   r_gone;
    logic   same;
    logic   shift_here;

    assign same = i_in_range && (r_entry.kind == i_cand.kind) && (r_entry.set == i_cand.set);
    assign o_beaten   = same && (r_entry.penalty <= i_cand.penalty)
                             && (r_entry.cost <= i_cand.cost);
    assign o_gone_now = same && !o_beaten && (i_cand.penalty <= r_entry.penalty)
                             && (i_cand.cost <= r_entry.cost);

    // every cell at or above the lowest hole moves down one place
    assign o_prefix   = i_prefix | r_gone;
    assign shift_here = i_ctl.shift && o_prefix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gone <= 1'b0;
        end else if (i_ctl.capture) begin
            r_gone <= o_gone_now;
        end else if (shift_here) begin
            r_gone <= i_nb_gone;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load && i_load_sel) begin
            r_entry <= i_cand;
        end else if (shift_here) begin
            r_entry <= i_nb_entry;
        end
    end

    assign o_entry = r_entry;
    assign o_gone  = r_gone;

endmodule

`default_nettype wire

[rtl/core/pareto_frontier_insert.sv]
// ----------------------------------------------------------------------------
// pareto_frontier_insert
// Bounded Pareto frontier over (penalty, cost) per item kind and key, kept
// as a row of compare-and-shift cells in insertion order.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its result appears
// on the o_ ports for one cycle with o_valid high and cannot be held off.
// Clear, read, no-op, rejected inserts and inserts that remove nothing
// finish in the compare state. An insert that removes held entries goes on
// through the shift state: every cell compares in parallel first,
// compaction then closes one hole per cycle through the
// neighbour-to-neighbour shift of the cell row, and a final step appends
// the new entry.
// ----------------------------------------------------------------------------
`default_nettype none

module pareto_frontier_insert
    import pfi_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         start,
    output logic        busy,
    input  wire  [1:0]  i_opcode,
    input  wire  [1:0]  i_item_kind,
    input  wire  [63:0] i_ench_set,
    input  wire  [5:0]  i_penalty,
    input  wire  [30:0] i_total_cost,
    input  wire  [3:0]  i_read_index,
    output logic        o_valid,
    output logic [1:0]  o_status,
    output logic [4:0]  o_removed_count,
    output logic [4:0]  o_entry_count,
    output logic [31:0] o_dropped_total,
    output logic        o_read_valid,
    output logic [1:0]  o_read_kind,
    output logic [63:0] o_read_set,
    output logic [5:0]  o_read_penalty,
    output logic [30:0] o_read_cost
);

    typedef enum logic [1:0] {S_IDLE, S_CMP, S_SHIFT} t_state;

    t_state             r_state;
    logic [1:0]         r_op;
    t_entry             r_cand;
    logic [3:0]         r_ridx;
    logic [FILL_W-1:0]  r_fill;
    logic [FILL_W-1:0]  r_removed;
    logic [31:0]        r_drop;

    logic               r_valid;
    logic [1:0]         r_status;
    logic [4:0]         r_removed_cnt;
    logic [4:0]         r_entry_cnt;
    logic               r_read_valid;
    t_entry             r_read;

    t_cell_ctl          ctl;
    t_entry             cell_entry [FRONTIER_DEPTH];
    logic [FRONTIER_DEPTH-1:0] cell_gone;
    logic [FRONTIER_DEPTH-1:0] cell_beaten;
    logic [FRONTIER_DEPTH-1:0] cell_gone_now;
    logic [FRONTIER_DEPTH-1:0] in_range;
    logic [FRONTIER_DEPTH-1:0] load_sel;
    logic [FRONTIER_DEPTH:0]   prefix;

    logic               beaten;
    logic               any_gone_now;
    logic               any_gone;
    logic               rd_hit;
    t_entry             rd_entry;

    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [FILL_W-1:0] b);
        logic [32:0] s;
        s = {1'b0, a} + 33'(b);
        sat_add = s[32] ? '1 : s[31:0];
    endfunction

    assign prefix[0] = 1'b0;

    for (genvar i = 0; i < FRONTIER_DEPTH; i++) begin : g_cell
        t_entry nb_entry;
        logic   nb_gone;

        if (i == FRONTIER_DEPTH - 1) begin : g_top
            assign nb_entry = cell_entry[i];
            assign nb_gone  = 1'b0;
        end else begin : g_mid
            assign nb_entry = cell_entry[i+1];
            assign nb_gone  = cell_gone[i+1];
        end

        assign in_range[i] = FILL_W'(i) < r_fill;
        assign load_sel[i] = FILL_W'(i) == r_fill;

        pfi_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (ctl),
            .i_cand     (r_cand),
            .i_in_range (in_range[i]),
            .i_load_sel (load_sel[i]),
            .i_nb_entry (nb_entry),
            .i_nb_gone  (nb_gone),
            .i_prefix   (prefix[i]),
            .o_entry    (cell_entry[i]),
            .o_gone     (cell_gone[i]),
            .o_prefix   (prefix[i+1]),
            .o_beaten   (cell_beaten[i]),
            .o_gone_now (cell_gone_now[i])
        );
    end

    assign beaten       = |cell_beaten;
    assign any_gone_now = |cell_gone_now;
    assign any_gone     = prefix[FRONTIER_DEPTH];

    always_comb begin
        rd_hit   = 1'b0;
        rd_entry = '0;
        for (int i = 0; i < FRONTIER_DEPTH; i++) begin
            if (i == int'(r_ridx) && in_range[i]) begin
                rd_hit   = 1'b1;
                rd_entry = cell_entry[i];
            end
        end
    end

    always_comb begin
        ctl = '0;
        if (r_state == S_CMP && r_op == OP_INSERT && !beaten) begin
            if (any_gone_now) begin
                ctl.capture = 1'b1;
            end else if (r_fill != FILL_W'(FRONTIER_DEPTH)) begin
                ctl.load = 1'b1;
            end
        end else if (r_state == S_SHIFT) begin
            ctl.shift = any_gone;
            ctl.load  = !any_gone;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
            r_drop  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_op    <= i_opcode;
                        r_cand  <= '{kind: i_item_kind, set: i_ench_set,
                                     penalty: i_penalty, cost: i_total_cost};
                        r_ridx  <= i_read_index;
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    r_removed     <= '0;
                    r_removed_cnt <= '0;
                    r_read_valid  <= 1'b0;
                    r_read        <= '0;
                    r_state       <= S_IDLE;
                    r_valid       <= 1'b1;
                    r_status      <= ST_DONE;
                    r_entry_cnt   <= sat5(r_fill);
                    case (r_op)
                        OP_INSERT: begin
                            if (beaten) begin
                                r_status <= ST_DOMINATED;
                                r_drop   <= sat_add(r_drop, FILL_W'(1));
                            end else if (any_gone_now) begin
                                r_valid <= 1'b0;
                                r_state <= S_SHIFT;
                            end else if (r_fill == FILL_W'(FRONTIER_DEPTH)) begin
                                r_status <= ST_FULL;
                                r_drop   <= sat_add(r_drop, FILL_W'(1));
                            end else begin
                                r_status    <= ST_INSERTED;
                                r_fill      <= r_fill + FILL_W'(1);
                                r_entry_cnt <= sat5(r_fill + FILL_W'(1));
                            end
                        end
                        OP_CLEAR: begin
                            r_fill      <= '0;
                            r_drop      <= '0;
                            r_entry_cnt <= '0;
                        end
                        OP_READ: begin
                            r_read_valid <= rd_hit;
                            r_read       <= rd_entry;
                        end
                        default: begin
                        end
                    endcase
                end
                S_SHIFT: begin
                    if (any_gone) begin
                        // one hole closed per cycle
                        r_fill    <= r_fill - FILL_W'(1);
                        r_removed <= r_removed + FILL_W'(1);
                    end else begin
                        r_fill        <= r_fill + FILL_W'(1);
                        r_drop        <= sat_add(r_drop, r_removed);
                        r_status      <= ST_INSERTED;
                        r_removed_cnt <= sat5(r_removed);
                        r_entry_cnt   <= sat5(r_fill + FILL_W'(1));
                        r_valid       <= 1'b1;
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy            = r_state != S_IDLE;
    assign o_valid         = r_valid;
    assign o_status        = r_status;
    assign o_removed_count = r_removed_cnt;
    assign o_entry_count   = r_entry_cnt;
    assign o_dropped_total = r_drop;
    assign o_read_valid    = r_read_valid;
    assign o_read_kind     = r_read.kind;
    assign o_read_set      = r_read.set;
    assign o_read_penalty  = r_read.penalty;
    assign o_read_cost     = r_read.cost;

endmodule

`default_nettype wire

[rtl/core/pfi_checker.sv]
// ----------------------------------------------------------------------------
// pfi_checker
// Port-level checks on the frontier insert block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pfi_checker
    import pfi_pkg::*;
(
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        start,
    input wire        busy,
    input wire        o_valid,
    input wire [1:0]  o_status,
    input wire [4:0]  o_removed_count,
    input wire        o_read_valid
);

    // an accepted item always leaves the block busy in the cycle after it is taken
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("item accepted but block not busy next cycle");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_idle_on_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result shown while still busy");

    a_removed_insert_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_INSERTED |-> o_removed_count == 5'd0)
        else $error("removals reported on a non-insert result");

    a_read_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_read_valid |-> o_status == ST_DONE)
        else $error("read hit reported with insert status");

endmodule

bind pareto_frontier_insert pfi_checker u_pfi_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_valid         (o_valid),
    .o_status        (o_status),
    .o_removed_count (o_removed_count),
    .o_read_valid    (o_read_valid)
);

`default_nettype wire

[tb/sv/pfi_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pfi_tb_checker
// Watches the command and result ports of the frontier insert block, keeps
// its own copy of the frontier, and checks every result against it in order.
// ----------------------------------------------------------------------------
`default_nettype none

module pfi_tb_checker
    import pfi_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_start,
    input  wire         i_busy,
    input  wire  [1:0]  i_opcode,
    input  wire  [1:0]  i_item_kind,
    input  wire  [63:0] i_ench_set,
    input  wire  [5:0]  i_penalty,
    input  wire  [30:0] i_total_cost,
    input  wire  [3:0]  i_read_index,
    input  wire         i_res_valid,
    input  wire  [1:0]  i_status,
    input  wire  [4:0]  i_removed_count,
    input  wire  [4:0]  i_entry_count,
    input  wire  [31:0] i_dropped_total,
    input  wire         i_read_valid,
    input  wire  [1:0]  i_read_kind,
    input  wire  [63:0] i_read_set,
    input  wire  [5:0]  i_read_penalty,
    input  wire  [30:0] i_read_cost,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [1:0]  status;
        logic [4:0]  removed;
        logic [4:0]  entries;
        logic [31:0] dropped;
        logic        rd_valid;
        logic [1:0]  rd_kind;
        logic [63:0] rd_set;
        logic [5:0]  rd_pen;
        logic [30:0] rd_cost;
    } t_outcome;

    t_entry      held [FRONTIER_DEPTH];
    int unsigned fill;
    logic [31:0] drops;
    t_outcome    outcomes_due [$];
    int          n_fail;

    function automatic logic [31:0] drops_plus(input logic [31:0] base, input int unsigned n);
        logic [32:0] sum;
        sum = {1'b0, base} + 33'(n);
        return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    endfunction

    function automatic logic [4:0] clip5(input int unsigned v);
        return (v > 31) ? 5'd31 : 5'(v);
    endfunction

    // one command applied to the frontier copy; returns what the block should report
    function automatic t_outcome frontier_step(input logic [1:0] op, input t_entry cand,
                                               input logic [3:0] ridx);
        t_outcome    r;
        bit          beaten;
        bit          gone [FRONTIER_DEPTH];
        int unsigned nrem;
        int unsigned w;
        r      = '0;
        r.status = ST_DONE;
        beaten = 0;
        nrem   = 0;
        w      = 0;
        case (op)
            OP_INSERT: begin
                for (int i = 0; i < FRONTIER_DEPTH; i++) begin
                    gone[i] = 0;
                    if (i < fill && held[i].kind == cand.kind && held[i].set == cand.set) begin
                        if (held[i].penalty <= cand.penalty && held[i].cost <= cand.cost)
                            beaten = 1;
                        else if (cand.penalty <= held[i].penalty && cand.cost <= held[i].cost)
                            gone[i] = 1;
                    end
                    if (gone[i])
                        nrem++;
                end
                if (beaten) begin
                    nrem     = 0;
                    r.status = ST_DOMINATED;
                    drops    = drops_plus(drops, 1);
                end else if (nrem == 0 && fill >= FRONTIER_DEPTH) begin
                    r.status = ST_FULL;
                    drops    = drops_plus(drops, 1);
                end else begin
                    // survivors close up in order, new entry goes last
                    for (int i = 0; i < fill; i++) begin
                        if (!gone[i]) begin
                            held[w] = held[i];
                            w++;
                        end
                    end
                    if (w < FRONTIER_DEPTH) begin
                        held[w] = cand;
                        w++;
                    end
                    fill     = w;
                    drops    = drops_plus(drops, nrem);
                    r.status = ST_INSERTED;
                end
            end
            OP_CLEAR: begin
                fill  = 0;
                drops = '0;
            end
            OP_READ: begin
                if (ridx < fill) begin
                    r.rd_valid = 1'b1;
                    r.rd_kind  = held[ridx].kind;
                    r.rd_set   = held[ridx].set;
                    r.rd_pen   = held[ridx].penalty;
                    r.rd_cost  = held[ridx].cost;
                end
            end
            default: ;
        endcase
        r.removed = clip5(nrem);
        r.entries = clip5(fill);
        r.dropped = drops;
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_outcome got;
        t_outcome want;
        t_outcome due;
        t_entry   cand;
        if (!i_rst_n) begin
            fill  = 0;
            drops = '0;
            outcomes_due.delete();
            n_fail = 0;
        end else begin
            // result first: it always belongs to an item taken at an earlier edge
            if (i_res_valid) begin
                got = {i_status, i_removed_count, i_entry_count, i_dropped_total,
                       i_read_valid, i_read_kind, i_read_set, i_read_penalty, i_read_cost};
                if (outcomes_due.size() == 0) begin
                    n_fail++;
                    if (n_fail <= 10)
                        $display("%0t: result with no item outstanding, status=%0d", $realtime,
                                 i_status);
                end else begin
                    want = outcomes_due.pop_front();
                    if (got !== want) begin
                        n_fail++;
                        if (n_fail <= 10) begin
                            $display("%0t: mismatch", $realtime);
                            $display("  exp st=%0d rm=%0d cnt=%0d drop=%0d rd=%0b k=%0d set=%h p=%0d c=%0d",
                                     want.status, want.removed, want.entries, want.dropped,
                                     want.rd_valid, want.rd_kind, want.rd_set, want.rd_pen,
                                     want.rd_cost);
                            $display("  got st=%0d rm=%0d cnt=%0d drop=%0d rd=%0b k=%0d set=%h p=%0d c=%0d",
                                     got.status, got.removed, got.entries, got.dropped,
                                     got.rd_valid, got.rd_kind, got.rd_set, got.rd_pen,
                                     got.rd_cost);
                        end
                    end
                end
            end
            if (i_start && !i_busy) begin
                cand.kind    = i_item_kind;
                cand.set     = i_ench_set;
                cand.penalty = i_penalty;
                cand.cost    = i_total_cost;
                due          = frontier_step(i_opcode, cand, i_read_index);
                outcomes_due.insert(outcomes_due.size(), due);
            end
        end
        o_fail_count <= n_fail;
        o_pending    <= outcomes_due.size();
    end

endmodule

`default_nettype wire

[tb/sv/pareto_frontier_insert_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pareto_frontier_insert_tb
// Drives the frontier insert block with directed corner cases, then with
// staircase frontiers per key mixed with random commands; a checker beside
// the block predicts and compares every result.
// ----------------------------------------------------------------------------
`default_nettype none

module pareto_frontier_insert_tb;
    import pfi_pkg::*;

    localparam logic [1:0] OP_NOP = 2'd3;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic [1:0]  i_opcode = OP_NOP;
    logic [1:0]  i_item_kind = '0;
    logic [63:0] i_ench_set = '0;
    logic [5:0]  i_penalty = '0;
    logic [30:0] i_total_cost = '0;
    logic [3:0]  i_read_index = '0;

    wire         busy;
    wire         o_valid;
    wire  [1:0]  o_status;
    wire  [4:0]  o_removed_count;
    wire  [4:0]  o_entry_count;
    wire  [31:0] o_dropped_total;
    wire         o_read_valid;
    wire  [1:0]  o_read_kind;
    wire  [63:0] o_read_set;
    wire  [5:0]  o_read_penalty;
    wire  [30:0] o_read_cost;

    int          n_fail;
    int          n_pending;
    int          n_sent;
    int          idle_rate;
    logic [63:0] key_pool [4];

    always #1 i_clk = ~i_clk;

    pareto_frontier_insert dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_opcode        (i_opcode),
        .i_item_kind     (i_item_kind),
        .i_ench_set      (i_ench_set),
        .i_penalty       (i_penalty),
        .i_total_cost    (i_total_cost),
        .i_read_index    (i_read_index),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_removed_count (o_removed_count),
        .o_entry_count   (o_entry_count),
        .o_dropped_total (o_dropped_total),
        .o_read_valid    (o_read_valid),
        .o_read_kind     (o_read_kind),
        .o_read_set      (o_read_set),
        .o_read_penalty  (o_read_penalty),
        .o_read_cost     (o_read_cost)
    );

    pfi_tb_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_busy          (busy),
        .i_opcode        (i_opcode),
        .i_item_kind     (i_item_kind),
        .i_ench_set      (i_ench_set),
        .i_penalty       (i_penalty),
        .i_total_cost    (i_total_cost),
        .i_read_index    (i_read_index),
        .i_res_valid     (o_valid),
        .i_status        (o_status),
        .i_removed_count (o_removed_count),
        .i_entry_count   (o_entry_count),
        .i_dropped_total (o_dropped_total),
        .i_read_valid    (o_read_valid),
        .i_read_kind     (o_read_kind),
        .i_read_set      (o_read_set),
        .i_read_penalty  (o_read_penalty),
        .i_read_cost     (o_read_cost),
        .o_fail_count    (n_fail),
        .o_pending       (n_pending)
    );

    // called at a rising edge; returns at the edge where the item is taken
    task automatic issue(input logic [1:0] op, input logic [1:0] kind, input logic [63:0] key,
                         input logic [5:0] pen, input logic [30:0] cost,
                         input logic [3:0] ridx);
        if (idle_rate != 0 && $urandom_range(0, 7) < idle_rate) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        start        <= 1'b1;
        i_opcode     <= op;
        i_item_kind  <= kind;
        i_ench_set   <= key;
        i_penalty    <= pen;
        i_total_cost <= cost;
        i_read_index <= ridx;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        n_sent++;
    endtask

    task automatic read_at(input logic [3:0] ridx);
        issue(OP_READ, 2'($urandom), {$urandom, $urandom}, 6'($urandom), 31'($urandom), ridx);
    endtask

    function automatic logic [63:0] pick_key();
        if ($urandom_range(0, 99) < 85)
            return key_pool[$urandom_range(0, 3)];
        return {$urandom, $urandom};
    endfunction

    // mutually non-dominated run on one key, at times closed by a dominating, partial or equal entry
    task automatic staircase_run();
        logic [1:0]  kind;
        logic [63:0] key;
        int          pen;
        int          cost;
        int          pen0;
        int          cost0;
        int          steps;
        kind  = 2'($urandom_range(0, 3));
        key   = pick_key();
        pen0  = $urandom_range(0, 8);
        cost0 = $urandom_range(20000, 40000);
        pen   = pen0;
        cost  = cost0;
        steps = $urandom_range(3, 20);
        for (int j = 0; j < steps; j++) begin
            issue(OP_INSERT, kind, key, 6'(pen), 31'(cost), '0);
            if ($urandom_range(0, 3) == 0)
                read_at(4'($urandom_range(0, 15)));
            pen  = (pen + $urandom_range(1, 3) > 63) ? 63 : pen + $urandom_range(1, 3);
            cost = cost - $urandom_range(1, 900);
        end
        case ($urandom_range(0, 3))
            0: issue(OP_INSERT, kind, key, 6'($urandom_range(0, pen0)),
                     31'($urandom_range(0, cost)), '0);
            1: issue(OP_INSERT, kind, key, 6'($urandom_range(pen0, pen)),
                     31'($urandom_range(cost, cost0)), '0);
            2: issue(OP_INSERT, kind, key, 6'(pen0), 31'(cost0), '0);
            default: ;
        endcase
    endtask

    task automatic noise_item();
        int          r;
        logic [5:0]  pen;
        logic [30:0] cost;
        r = $urandom_range(0, 19);
        if ($urandom_range(0, 9) < 7)
            pen = 6'($urandom_range(0, 15));
        else
            pen = 6'($urandom);
        case ($urandom_range(0, 3))
            0, 1: cost = 31'($urandom_range(0, 63));
            2: cost = 31'($urandom);
            default: cost = 31'h7FFF_FFFF - 31'($urandom_range(0, 15));
        endcase
        if (r == 0)
            issue(OP_CLEAR, 2'($urandom), {$urandom, $urandom}, pen, cost, 4'($urandom));
        else if (r == 1)
            issue(OP_NOP, 2'($urandom), {$urandom, $urandom}, pen, cost, 4'($urandom));
        else if (r <= 5)
            read_at(4'($urandom_range(0, 15)));
        else
            issue(OP_INSERT, 2'($urandom), pick_key(), pen, cost, 4'($urandom));
    endtask

    initial begin
        #400000;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        n_sent      = 0;
        idle_rate   = 2;
        key_pool[0] = '1;
        key_pool[1] = '0;
        key_pool[2] = {$urandom, $urandom};
        key_pool[3] = {$urandom, $urandom};
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty table, no-op, extremes of the fields
        read_at(4'd0);
        issue(OP_NOP, 2'd0, '0, 6'd0, 31'd0, 4'd15);
        issue(OP_INSERT, 2'd0, '0, 6'd0, 31'd0, 4'd0);
        issue(OP_INSERT, 2'd0, '0, 6'd0, 31'd0, 4'd0);          // equal entry: dominated
        issue(OP_INSERT, 2'd3, '1, 6'd63, 31'h7FFF_FFFF, 4'd15);
        issue(OP_INSERT, 2'd3, '1, 6'd62, 31'h7FFF_FFFE, 4'd15); // removes the one above
        read_at(4'd1);
        read_at(4'd15);
        issue(OP_CLEAR, 2'd0, '0, 6'd0, 31'd0, 4'd0);
        // fill to depth on one key, then full, removal while full, dominated while full
        for (int j = 0; j < FRONTIER_DEPTH; j++)
            issue(OP_INSERT, 2'd1, key_pool[2], 6'(j * 2), 31'(1000 - j * 10), '0);
        issue(OP_INSERT, 2'd1, key_pool[2], 6'd40, 31'd500, '0);
        issue(OP_INSERT, 2'd1, key_pool[2], 6'd2, 31'd985, '0);
        issue(OP_INSERT, 2'd1, key_pool[2], 6'd31, 31'd2000, '0);
        read_at(4'd15);
        issue(OP_INSERT, 2'd1, key_pool[2], 6'd0, 31'd0, '0);    // sweeps the whole table
        read_at(4'd0);

        while (n_sent < 450) begin
            idle_rate = (n_sent > 370) ? 0 : $urandom_range(0, 3);
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: staircase_run();
                5, 6, 7, 8: repeat ($urandom_range(5, 20)) noise_item();
                default: issue(OP_CLEAR, 2'($urandom), {$urandom, $urandom}, 6'($urandom),
                               31'($urandom), 4'($urandom));
            endcase
        end
        start <= 1'b0;

        for (int w = 0; w < 2000 && n_pending != 0; w++)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (n_fail == 0 && n_pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

[files.f]
rtl/core/pfi_pkg.sv
rtl/core/pfi_cell.sv
rtl/core/pareto_frontier_insert.sv
rtl/core/pfi_checker.sv
tb/sv/pfi_checker.sv
tb/sv/pareto_frontier_insert_tb.sv
